FILE: rtl/tccs_pkg.sv
// ----------------------------------------------------------------------------
// tccs_pkg
// Shared types and constants of the text console writer.
// ----------------------------------------------------------------------------
package tccs_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned CellW   = CharW + ColorW;
  localparam int unsigned IndexW  = 11;
  localparam int unsigned RowOutW = 5;
  localparam int unsigned ColOutW = 7;

  localparam logic [CharW-1:0]  NewlineCode = 8'd10;
  localparam logic [CharW-1:0]  SpaceCode   = 8'd32;
  localparam logic [ColorW-1:0] ResetColor  = 8'h07;
  localparam logic [CellW-1:0]  ResetCell   = 16'h0720;

  localparam logic OpPut  = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic [CellW-1:0]   cell_value;
    logic [RowOutW-1:0] cursor_row;
    logic [ColOutW-1:0] cursor_column;
    logic               scrolled;
  } rsp_t;

endpackage

FILE: rtl/tccs_if.sv
// ----------------------------------------------------------------------------
// tccs_if
// Request and response channels of the text console writer.
// ----------------------------------------------------------------------------
interface tccs_req_if
  import tccs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              op;
  logic [CharW-1:0]  char_code;
  logic [IndexW-1:0] cell_index;

  modport source (output valid, output op, output char_code, output cell_index, input ready);
  modport sink   (input valid, input op, input char_code, input cell_index, output ready);
endinterface

interface tccs_rsp_if
  import tccs_pkg::*;
;
  logic               valid;
  logic               ready;
  logic [CellW-1:0]   cell_value;
  logic [RowOutW-1:0] cursor_row;
  logic [ColOutW-1:0] cursor_column;
  logic               scrolled;

  modport source (output valid, output cell_value, output cursor_row,
                  output cursor_column, output scrolled, input ready);
  modport sink   (input valid, input cell_value, input cursor_row,
                  input cursor_column, input scrolled, output ready);
endinterface

FILE: rtl/tccs_ram.sv
// ----------------------------------------------------------------------------
// tccs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tccs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/tccs_out_reg.sv
// ----------------------------------------------------------------------------
// tccs_out_reg
// Response output register, holds a word until the sink takes it.
// ----------------------------------------------------------------------------
module tccs_out_reg
  import tccs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  rsp_t              rsp_i,
  output logic              free_o,
  tccs_rsp_if.source        rsp_o
);

  logic valid_q;
  rsp_t data_q;

  assign free_o = !valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i && free_o) begin
      valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      data_q <= rsp_i;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.cell_value    = data_q.cell_value;
  assign rsp_o.cursor_row    = data_q.cursor_row;
  assign rsp_o.cursor_column = data_q.cursor_column;
  assign rsp_o.scrolled      = data_q.scrolled;

endmodule

FILE: rtl/text_console_cursor_scroll.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console writer: cursor, line wrap and scroll-up over a cell store.
//
//   channel   dir  handshake        payload
//   req_i     in   valid / ready    op, char_code, cell_index
//   rsp_o     out  valid / ready    cell_value, cursor_row, cursor_column, scrolled
//   cfg       in   cfg_we_i         cfg_wdata_i (text colour)
//
// a put or a read reaches rsp_o through ST_RESP and the output register; no new request is taken until then
// a scroll walks the store through one read and one write a cycle, over every cell
// after reset a clearing pass writes every cell, with req_i not ready
// a held response blocks the next request; req_i waits for the output register and the sequencer
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
  import tccs_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tccs_req_if.sink          req_i,
  tccs_rsp_if.source        rsp_o,
  input  logic              cfg_we_i,
  input  logic [ColorW-1:0] cfg_wdata_i
);

  localparam int unsigned Cells    = COLUMNS * ROWS;
  localparam int unsigned LastBase = Cells - COLUMNS;
  localparam int unsigned AW       = $clog2(Cells);
  localparam int unsigned LW       = $clog2(Cells + 1);
  localparam int unsigned RW       = $clog2(ROWS);
  localparam int unsigned CW       = $clog2(COLUMNS + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SHIFT,
    ST_RESP
  } state_e;

  state_e            state_q;
  logic [RW-1:0]     row_q;
  logic [CW-1:0]     col_q;
  logic [AW-1:0]     base_q;
  logic [LW-1:0]     lin_q;
  logic [AW-1:0]     ptr_q;
  logic [ColorW-1:0] color_q;
  logic [CharW-1:0]  char_q;
  logic              pend_q;
  logic              scr_q;
  logic              rd_pend_q;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CellW-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [CellW-1:0]  ram_rdata;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic [31:0]       idx_w;
  logic              in_range;
  logic              last_row;
  logic              line_full;
  logic              is_newline;
  logic              copying;
  logic [31:0]       next_rd;
  logic [31:0]       row_w;
  logic [31:0]       col_w;
  rsp_t              rsp;

  assign req_i.ready = (state_q == ST_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign idx_w       = 32'(req_i.cell_index);
  assign in_range    = idx_w < 32'(Cells);
  assign last_row    = (row_q == RW'(ROWS - 1));
  assign line_full   = (col_q == CW'(COLUMNS));
  assign is_newline  = (req_i.char_code == NewlineCode);
  assign copying     = 32'(ptr_q) < 32'(LastBase);
  assign next_rd     = 32'(ptr_q) + 32'(COLUMNS) + 32'd1;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q;
    ram_wdata = ResetCell;
    ram_re    = 1'b0;
    ram_raddr = idx_w[AW-1:0];
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept) begin
          if (req_i.op == OpRead) begin
            ram_re = in_range;
          end else if (is_newline || line_full) begin
            if (last_row) begin
              ram_re    = 1'b1;
              ram_raddr = AW'(COLUMNS);
            end else if (!is_newline) begin
              ram_we    = 1'b1;
              ram_waddr = lin_q[AW-1:0];
              ram_wdata = {color_q, req_i.char_code};
            end
          end else begin
            ram_we    = 1'b1;
            ram_waddr = lin_q[AW-1:0];
            ram_wdata = {color_q, req_i.char_code};
          end
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_re    = next_rd < 32'(Cells);
        ram_raddr = next_rd[AW-1:0];
        if (copying) begin
          ram_wdata = ram_rdata;
        end else if (pend_q && (ptr_q == AW'(LastBase))) begin
          ram_wdata = {color_q, char_q};
        end else begin
          ram_wdata = {color_q, SpaceCode};
        end
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= ResetColor;
    end else if (cfg_we_i) begin
      color_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      row_q     <= '0;
      col_q     <= '0;
      base_q    <= '0;
      lin_q     <= '0;
      ptr_q     <= '0;
      char_q    <= '0;
      pend_q    <= 1'b0;
      scr_q     <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == AW'(Cells - 1)) begin
            ptr_q   <= '0;
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            scr_q     <= 1'b0;
            rd_pend_q <= 1'b0;
            state_q   <= ST_RESP;
            if (req_i.op == OpRead) begin
              rd_pend_q <= in_range;
            end else if (is_newline) begin
              col_q <= '0;
              if (last_row) begin
                scr_q   <= 1'b1;
                pend_q  <= 1'b0;
                ptr_q   <= '0;
                state_q <= ST_SHIFT;
              end else begin
                row_q  <= row_q + RW'(1);
                base_q <= base_q + AW'(COLUMNS);
                lin_q  <= LW'(base_q) + LW'(COLUMNS);
              end
            end else if (!line_full) begin
              col_q <= col_q + CW'(1);
              lin_q <= lin_q + LW'(1);
            end else if (!last_row) begin
              row_q  <= row_q + RW'(1);
              base_q <= lin_q[AW-1:0];
              col_q  <= CW'(1);
              lin_q  <= lin_q + LW'(1);
            end else begin
              scr_q   <= 1'b1;
              pend_q  <= 1'b1;
              char_q  <= req_i.char_code;
              ptr_q   <= '0;
              state_q <= ST_SHIFT;
            end
          end
        end
        ST_SHIFT: begin
          ptr_q <= ptr_q + AW'(1);
          if (ptr_q == AW'(Cells - 1)) begin
            ptr_q   <= '0;
            col_q   <= pend_q ? CW'(1) : '0;
            lin_q   <= LW'(LastBase) + (pend_q ? LW'(1) : '0);
            state_q <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_load          = (state_q == ST_RESP);
  assign row_w             = 32'(row_q);
  assign col_w             = 32'(col_q);
  assign rsp.cell_value    = rd_pend_q ? ram_rdata : '0;
  assign rsp.cursor_row    = row_w[RowOutW-1:0];
  assign rsp.cursor_column = col_w[ColOutW-1:0];
  assign rsp.scrolled      = scr_q;

  tccs_ram #(
    .Width (CellW),
    .Depth (Cells)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tccs_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_load),
    .rsp_i  (rsp),
    .free_o (out_free),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: rtl/tccs_chk.sv
// ----------------------------------------------------------------------------
// tccs_chk
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tccs_chk
  import tccs_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               req_valid_i,
  input logic               req_ready_i,
  input logic               rsp_valid_i,
  input logic               rsp_ready_i,
  input logic [CellW-1:0]   rsp_cell_value_i,
  input logic [RowOutW-1:0] rsp_cursor_row_i,
  input logic [ColOutW-1:0] rsp_cursor_column_i,
  input logic               rsp_scrolled_i
);

  // a request is never accepted twice in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted twice in a row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_cell_value_i)
      && $stable(rsp_cursor_row_i) && $stable(rsp_cursor_column_i)
      && $stable(rsp_scrolled_i))
    else $error("stalled response changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> 32'(rsp_cursor_column_i) <= COLUMNS)
    else $error("cursor column beyond line end");

  // a scroll leaves the cursor on the bottom row, at column 0 or 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_scrolled_i |->
      rsp_cursor_row_i == RowOutW'(ROWS - 1)
      && (rsp_cursor_column_i == '0 || rsp_cursor_column_i == ColOutW'(1)))
    else $error("scroll left cursor off bottom row");

endmodule

bind text_console_cursor_scroll tccs_chk #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccs_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_cell_value_i    (rsp_o.cell_value),
  .rsp_cursor_row_i    (rsp_o.cursor_row),
  .rsp_cursor_column_i (rsp_o.cursor_column),
  .rsp_scrolled_i      (rsp_o.scrolled)
);

FILE: tb/text_console_cursor_scroll_tb.sv
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Checks the text console writer against a cycle-free model of its screen:
// cursor moves, line wrap, scroll-up with blank fill and cell reads. Every
// word on the response channel is compared field by field with the oldest
// prediction. Stimulus is a short directed set, then random text lines of
// varied length with newlines and reads, under several text colours, plus
// random noise. The sender works in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb
  import tccs_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int Columns   = 80;
  localparam int Rows      = 25;
  localparam int CellCount = Columns * Rows;
  localparam int IndexMax  = 2 ** IndexW - 1;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we;
  logic [ColorW-1:0] cfg_wdata;

  tccs_req_if req_bus ();
  tccs_rsp_if rsp_bus ();

  text_console_cursor_scroll #(
    .COLUMNS(Columns),
    .ROWS   (Rows)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_bus.sink),
    .rsp_o      (rsp_bus.source),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // screen model
  logic [CellW-1:0]  screen_model [CellCount];
  logic [ColorW-1:0] color_model;
  int                cursor_row;
  int                cursor_col;

  rsp_t        expected_words [$];
  int unsigned mismatch_count;
  int unsigned sent_count;
  int unsigned burst_left;
  bit          gaps_on;
  bit          req_active;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

  function automatic bit advance_line();
    cursor_col = 0;
    if (cursor_row < Rows - 1) begin
      cursor_row++;
      return 1'b0;
    end
    for (int i = 0; i < CellCount - Columns; i++) screen_model[i] = screen_model[i + Columns];
    for (int i = CellCount - Columns; i < CellCount; i++) screen_model[i] = {color_model, SpaceCode};
    return 1'b1;
  endfunction

  function automatic rsp_t predict_console(input logic op, input logic [CharW-1:0] ch,
                                           input logic [IndexW-1:0] idx);
    rsp_t r;
    r = '0;
    if (op == OpRead) begin
      if (idx < CellCount) r.cell_value = screen_model[idx];
    end else if (ch == NewlineCode) begin
      r.scrolled = advance_line();
    end else begin
      if (cursor_col >= Columns) r.scrolled = advance_line();
      screen_model[cursor_row * Columns + cursor_col] = {color_model, ch};
      cursor_col++;
    end
    r.cursor_row    = cursor_row[RowOutW-1:0];
    r.cursor_column = cursor_col[ColOutW-1:0];
    return r;
  endfunction

  function automatic logic [CharW-1:0] random_glyph();
    logic [CharW-1:0] c;
    do c = CharW'($urandom_range(0, 255)); while (c == NewlineCode);
    return c;
  endfunction

  function automatic logic [IndexW-1:0] pick_read_index();
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 40) return IndexW'(cursor_row * Columns + $urandom_range(0, Columns - 1));
    if (kind < 65) return IndexW'((Rows - 1) * Columns + $urandom_range(0, Columns - 1));
    if (kind < 90) return IndexW'($urandom_range(0, CellCount - 1));
    return IndexW'($urandom_range(CellCount, IndexMax));
  endfunction

  task automatic release_bus();
    if (req_active) begin
      req_bus.valid <= 1'b0;
      req_active = 1'b0;
    end
  endtask

  task automatic send_word(input logic op, input logic [CharW-1:0] ch,
                           input logic [IndexW-1:0] idx);
    req_bus.valid      <= 1'b1;
    req_bus.op         <= op;
    req_bus.char_code  <= ch;
    req_bus.cell_index <= idx;
    req_active = 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    expected_words.push_back(predict_console(op, ch, idx));
    sent_count++;
    if (gaps_on) begin
      if (burst_left == 0) begin
        release_bus();
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic wait_idle();
    release_bus();
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_text_color(input logic [ColorW-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    color_model = value;
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_contents();
    send_word(OpRead, 8'h00, 11'd0);
    send_word(OpRead, 8'hFF, 11'd1);
    send_word(OpRead, 8'h00, IndexW'(CellCount - 1));
    send_word(OpRead, NewlineCode, IndexW'(CellCount));
    send_word(OpRead, 8'h55, IndexW'(IndexMax));
    send_word(OpRead, 8'hAA, 11'd1024);
  endtask

  task automatic test_put_and_read();
    set_text_color(8'hFF);
    send_word(OpPut, 8'h00, IndexW'(IndexMax));
    send_word(OpPut, 8'hFF, 11'd0);
    send_word(OpPut, NewlineCode, 11'h555);
    send_word(OpPut, 8'h41, 11'h2AA);
    send_word(OpRead, 8'h00, 11'd0);
    send_word(OpRead, 8'h00, 11'd1);
    send_word(OpRead, 8'h00, IndexW'(Columns));
    send_word(OpRead, 8'h00, IndexW'(Columns + 1));
    set_text_color(8'h00);
    send_word(OpPut, NewlineCode, 11'd0);
    send_word(OpPut, 8'h7E, 11'd0);
    send_word(OpRead, 8'hFF, IndexW'(2 * Columns));
    send_word(OpRead, 8'hFF, IndexW'(IndexMax - 1));
  endtask

  // text lines: short, medium, near full, and long enough to wrap
  task automatic test_console_lines(input int unsigned item_goal);
    int unsigned goal;
    int unsigned kind;
    int unsigned len;
    int unsigned breaks;
    goal = sent_count + item_goal;
    while (sent_count < goal) begin
      kind = $urandom_range(0, 99);
      if (kind < 55) len = $urandom_range(0, 12);
      else if (kind < 80) len = $urandom_range(13, Columns - 3);
      else if (kind < 92) len = $urandom_range(Columns - 2, Columns + 2);
      else len = $urandom_range(Columns + 3, 2 * Columns + 10);
      repeat (len) send_word(OpPut, random_glyph(), IndexW'($urandom_range(0, IndexMax)));
      breaks = 0;
      if ($urandom_range(0, 3) != 0) begin
        breaks = 1;
        if ($urandom_range(0, 4) == 0) breaks += $urandom_range(1, 3);
      end
      repeat (breaks) send_word(OpPut, NewlineCode, IndexW'($urandom_range(0, IndexMax)));
      repeat ($urandom_range(0, 3))
        send_word(OpRead, CharW'($urandom_range(0, 255)), pick_read_index());
    end
  endtask

  task automatic test_noise(input int unsigned item_goal);
    logic             op;
    logic [CharW-1:0] ch;
    repeat (item_goal) begin
      op = 1'($urandom_range(0, 1));
      ch = ($urandom_range(0, 9) == 0) ? NewlineCode : CharW'($urandom_range(0, 255));
      send_word(op, ch, IndexW'($urandom_range(0, IndexMax)));
    end
  endtask

  // receiver stalls in stretches of differing character
  initial begin
    int unsigned span;
    int unsigned mode;
    int unsigned tick;
    span = 0;
    tick = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (span == 0) begin
        mode = $urandom_range(0, 3);
        span = $urandom_range(32, 300);
      end
      span--;
      tick++;
      case (mode)
        0: begin
          rsp_bus.ready <= 1'b1;
        end
        1: begin
          rsp_bus.ready <= ($urandom_range(0, 9) < 6);
        end
        2: begin
          rsp_bus.ready <= (tick % 8 == 0);
        end
        default: begin
          rsp_bus.ready <= (span < 8);
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_words
    rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: cell_value %h row %0d column %0d scrolled %0b",
               rsp_bus.cell_value, rsp_bus.cursor_row, rsp_bus.cursor_column, rsp_bus.scrolled);
        mismatch_count++;
      end else begin
        want = expected_words.pop_front();
        if (rsp_bus.cell_value !== want.cell_value) begin
          $error("cell_value: expected %h, got %h", want.cell_value, rsp_bus.cell_value);
          mismatch_count++;
        end
        if (rsp_bus.cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, got %0d", want.cursor_row, rsp_bus.cursor_row);
          mismatch_count++;
        end
        if (rsp_bus.cursor_column !== want.cursor_column) begin
          $error("cursor_column: expected %0d, got %0d", want.cursor_column,
                 rsp_bus.cursor_column);
          mismatch_count++;
        end
        if (rsp_bus.scrolled !== want.scrolled) begin
          $error("scrolled: expected %0b, got %0b", want.scrolled, rsp_bus.scrolled);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < CellCount; i++) screen_model[i] = ResetCell;
    color_model    = ResetColor;
    cursor_row     = 0;
    cursor_col     = 0;
    mismatch_count = 0;
    sent_count     = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    req_active     = 1'b0;

    rst_ni             <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_bus.valid      <= 1'b0;
    req_bus.op         <= OpPut;
    req_bus.char_code  <= '0;
    req_bus.cell_index <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_contents();
    test_put_and_read();

    set_text_color(8'h00);
    test_console_lines(400);
    set_text_color(8'hFF);
    gaps_on = 1'b0;
    test_console_lines(400);
    set_text_color(ColorW'($urandom_range(1, 254)));
    gaps_on = 1'b1;
    test_console_lines(400);
    test_noise(150);
    set_text_color(ResetColor);
    test_console_lines(380);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/tccs_pkg.sv
rtl/tccs_if.sv
rtl/tccs_ram.sv
rtl/tccs_out_reg.sv
rtl/text_console_cursor_scroll.sv
rtl/tccs_chk.sv
tb/text_console_cursor_scroll_tb.sv
